// ----- rtl/core/psd_pkg.sv -----
`default_nettype none
package psd_pkg;

  // Field widths
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned COORD_W   = 64;
  localparam int unsigned PAYLOAD_W = 5;
  localparam int unsigned CHUNK_W   = 6;

  // Chunk limit: default and the largest supported value
  localparam int unsigned MAX_CHUNKS_DEF = 12;
  localparam int unsigned MAX_CHUNKS_LIM = 12;

  // Widest gathered number, sized for the largest chunk limit
  localparam int unsigned NUM_W = PAYLOAD_W * MAX_CHUNKS_LIM;

  // Valid character range and chunk continuation flag
  localparam logic [SYM_W-1:0] SYM_LOW  = 8'd63;
  localparam logic [SYM_W-1:0] SYM_HIGH = 8'd126;
  localparam int unsigned      CONT_BIT = 5;

  // Command queue depth
  localparam int unsigned FIFO_DEPTH = 2;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_PAIR     = 2'd0,
    STATUS_BAD_SYM  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  // Command from the front end to the back end
  typedef struct packed {
    logic             clear;    // zero both sums before acting
    logic             is_err;   // error report, no accumulation
    status_t          status;   // error kind when is_err
    logic [SYM_W-1:0] bad_sym;  // offending character for a bad symbol
    logic             sel;      // 0 = latitude, 1 = longitude
    logic [NUM_W-1:0] num;      // gathered number, still zigzag coded
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/psd_in_if.sv -----
`default_nettype none
interface psd_in_if;
  import psd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink   (input valid, input symbol, input first, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/psd_out_if.sv -----
`default_nettype none
interface psd_out_if;
  import psd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [COORD_W-1:0] lat_value;
  logic signed [COORD_W-1:0] lng_value;
  logic [SYM_W-1:0]          bad_symbol;

  modport source (output valid, output status, output lat_value, output lng_value,
                  output bad_symbol, input ready);
  modport sink   (input valid, input status, input lat_value, input lng_value,
                  input bad_symbol, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/psd_front.sv -----
`default_nettype none
module psd_front #(
  parameter int unsigned MAX_CHUNKS = psd_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [psd_pkg::SYM_W-1:0] in_symbol,
  input  wire logic                     in_first,
  input  wire logic                     q_full,
  output logic                          q_push,
  output psd_pkg::cmd_t                 q_cmd
);
  import psd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  logic             failed_r, failed_nxt;
  logic             sel_r, sel_nxt;
  logic             clr_pend_r, clr_pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] part_r, part_nxt;

  logic             accept;
  logic             eff_failed;
  logic             eff_sel;
  logic [CNT_W-1:0] eff_cnt;
  logic [NUM_W-1:0] eff_part;
  logic [NUM_W-1:0] ins;
  logic [CHUNK_W-1:0] chunk;
  logic             sym_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A new string wipes the decoding state before this symbol
  assign eff_failed = in_first ? 1'b0 : failed_r;
  assign eff_sel    = in_first ? 1'b0 : sel_r;
  assign eff_cnt    = in_first ? '0 : cnt_r;
  assign eff_part   = in_first ? '0 : part_r;

  assign sym_ok = (in_symbol >= SYM_LOW) && (in_symbol <= SYM_HIGH);
  assign chunk  = CHUNK_W'(in_symbol - SYM_LOW);

  // Place the payload in the lane picked by the chunk count
  always_comb begin
    ins = '0;
    for (int i = 0; i < int'(MAX_CHUNKS); i++) begin
      if (eff_cnt == CNT_W'(i)) begin
        ins[i*PAYLOAD_W +: PAYLOAD_W] = chunk[PAYLOAD_W-1:0];
      end
    end
  end

  // Classify the symbol and build the command
  always_comb begin
    failed_nxt   = failed_r;
    sel_nxt      = sel_r;
    cnt_nxt      = cnt_r;
    part_nxt     = part_r;
    clr_pend_nxt = clr_pend_r;
    q_push       = 1'b0;
    q_cmd.clear   = clr_pend_r || in_first;
    q_cmd.is_err  = 1'b0;
    q_cmd.status  = STATUS_PAIR;
    q_cmd.bad_sym = '0;
    q_cmd.sel     = eff_sel;
    q_cmd.num     = eff_part | ins;
    if (accept) begin
      failed_nxt   = eff_failed;
      sel_nxt      = eff_sel;
      cnt_nxt      = eff_cnt;
      part_nxt     = eff_part;
      clr_pend_nxt = clr_pend_r || in_first;
      if (!eff_failed) begin
        if (!sym_ok) begin
          q_push        = 1'b1;
          q_cmd.is_err  = 1'b1;
          q_cmd.status  = STATUS_BAD_SYM;
          q_cmd.bad_sym = in_symbol;
          failed_nxt    = 1'b1;
        end else if (eff_cnt >= CNT_W'(MAX_CHUNKS)) begin
          q_push       = 1'b1;
          q_cmd.is_err = 1'b1;
          q_cmd.status = STATUS_TOO_LONG;
          failed_nxt   = 1'b1;
        end else if (chunk[CONT_BIT]) begin
          cnt_nxt  = eff_cnt + CNT_W'(1);
          part_nxt = eff_part | ins;
        end else begin
          q_push   = 1'b1;
          cnt_nxt  = '0;
          part_nxt = '0;
          sel_nxt  = !eff_sel;
        end
      end
      // The pending clear rides on the first command pushed
      if (q_push) begin
        clr_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r   <= 1'b0;
      sel_r      <= 1'b0;
      cnt_r      <= '0;
      part_r     <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      failed_r   <= failed_nxt;
      sel_r      <= sel_nxt;
      cnt_r      <= cnt_nxt;
      part_r     <= part_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/psd_fifo.sv -----
`default_nettype none
module psd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire psd_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output psd_pkg::cmd_t      pop_cmd
);
  import psd_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/psd_back.sv -----
`default_nettype none
module psd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire psd_pkg::cmd_t q_cmd,
  output logic               q_pop,
  psd_out_if.source          out_ch
);
  import psd_pkg::*;

  logic [COORD_W-1:0] lat_r, lat_nxt;
  logic [COORD_W-1:0] lng_r, lng_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [COORD_W-1:0] out_lat_r, out_lat_nxt;
  logic [COORD_W-1:0] out_lng_r, out_lng_nxt;
  logic [SYM_W-1:0]   out_bad_r, out_bad_nxt;

  logic [COORD_W-1:0] num_ext;
  logic [COORD_W-1:0] delta;
  logic [COORD_W-1:0] base_lat, base_lng;
  logic [COORD_W-1:0] sum_in, sum_out;

  // Take a command whenever the output register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  // Zigzag decode
  assign num_ext = COORD_W'(q_cmd.num);
  assign delta   = num_ext[0] ? ~(num_ext >> 1) : (num_ext >> 1);

  assign base_lat = q_cmd.clear ? '0 : lat_r;
  assign base_lng = q_cmd.clear ? '0 : lng_r;
  assign sum_in   = q_cmd.sel ? base_lng : base_lat;
  assign sum_out  = sum_in + delta;

  // Accumulate and load the output register
  always_comb begin
    lat_nxt        = lat_r;
    lng_nxt        = lng_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_lat_nxt    = out_lat_r;
    out_lng_nxt    = out_lng_r;
    out_bad_nxt    = out_bad_r;
    if (q_pop) begin
      lat_nxt = base_lat;
      lng_nxt = base_lng;
      if (q_cmd.is_err) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = q_cmd.status;
        out_lat_nxt    = '0;
        out_lng_nxt    = '0;
        out_bad_nxt    = q_cmd.bad_sym;
      end else if (q_cmd.sel) begin
        lng_nxt        = sum_out;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_PAIR;
        out_lat_nxt    = base_lat;
        out_lng_nxt    = sum_out;
        out_bad_nxt    = '0;
      end else begin
        lat_nxt = sum_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r       <= '0;
      lng_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lat_r       <= lat_nxt;
      lng_r       <= lng_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_lat_r    <= out_lat_nxt;
    out_lng_r    <= out_lng_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.lat_value  = signed'(out_lat_r);
  assign out_ch.lng_value  = signed'(out_lng_r);
  assign out_ch.bad_symbol = out_bad_r;

endmodule
`default_nettype wire

// ----- rtl/core/polyline_stream_decoder_unit.sv -----
// Encoded polyline decoder.
// in_ch takes one character per transaction (symbol, first). Set first on
// the opening character of a string; it clears the running sums and any
// partial number before the character is decoded.
// out_ch gives one transaction per decoded longitude (status pair, both
// running sums as 64-bit scaled integers) and one per error (bad character
// or a number longer than MAX_CHUNKS chunks). After an error the block drops
// characters without result until the next one with first set.
// Throughput: one character per cycle while the command queue is not full.
// The front end decodes each character combinationally; the back end does the
// zigzag decode and one 64-bit add per cycle into the output register, while
// that register is free or draining. A result goes from the front end through
// the two-entry command queue into the output register.
// When the receiver stalls, the output register holds and the queue fills;
// in_ch.ready drops only once the queue is full.
// Reset clears all decoding state; the block accepts characters as soon as
// reset is released.
`default_nettype none
module polyline_stream_decoder_unit #(
  parameter int unsigned MAX_CHUNKS = psd_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch
);
  import psd_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  psd_front #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_symbol(in_ch.symbol),
    .in_first (in_ch.first),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  psd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .pop_cmd (back_cmd)
  );

  psd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_cmd  (back_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Decoded result as seen on the output channel
typedef struct {
  psd_pkg::status_t    status;
  logic signed [63:0]  lat;
  logic signed [63:0]  lng;
  logic [7:0]          bad;
} polyline_result_t;

// Tracks the decoder state per accepted character and checks each result
class polyline_tracker;
  logic [63:0]      run_sum[2];   // [0] latitude, [1] longitude
  logic [63:0]      gathered;
  int unsigned      n_chunks;
  bit               lng_next;
  bit               halted;
  int unsigned      chunk_limit;
  polyline_result_t results_due[$];
  int               errors;
  int               decoded_chars;

  function new(int unsigned limit);
    chunk_limit   = limit;
    errors        = 0;
    decoded_chars = 0;
    restart();
  endfunction

  function void restart();
    run_sum[0] = '0;
    run_sum[1] = '0;
    gathered   = '0;
    n_chunks   = 0;
    lng_next   = 1'b0;
    halted     = 1'b0;
  endfunction

  // Advance the decoder by one accepted character
  function void decode_char(logic [7:0] sym, logic opens);
    logic [5:0]       chunk;
    logic [63:0]      delta;
    polyline_result_t r;
    if (opens) restart();
    if (halted) return;
    decoded_chars++;
    if (sym < psd_pkg::SYM_LOW || sym > psd_pkg::SYM_HIGH) begin
      halted = 1'b1;
      r = '{status: psd_pkg::STATUS_BAD_SYM, lat: '0, lng: '0, bad: sym};
      results_due.push_back(r);
      return;
    end
    if (n_chunks >= chunk_limit) begin
      halted = 1'b1;
      r = '{status: psd_pkg::STATUS_TOO_LONG, lat: '0, lng: '0, bad: '0};
      results_due.push_back(r);
      return;
    end
    chunk    = 6'(sym - psd_pkg::SYM_LOW);
    gathered = gathered | (64'(chunk[4:0]) << (5 * n_chunks));
    n_chunks++;
    if (chunk[psd_pkg::CONT_BIT]) return;
    // zigzag decode, then accumulate into the selected coordinate
    delta = gathered[0] ? ~(gathered >> 1) : (gathered >> 1);
    run_sum[lng_next] = run_sum[lng_next] + delta;
    gathered = '0;
    n_chunks = 0;
    if (lng_next) begin
      r = '{status: psd_pkg::STATUS_PAIR, lat: run_sum[0], lng: run_sum[1], bad: '0};
      results_due.push_back(r);
    end
    lng_next = !lng_next;
  endfunction

  // Compare one output transaction with the oldest expectation
  function void check_result(logic [1:0] status, logic signed [63:0] lat,
                             logic signed [63:0] lng, logic [7:0] bad);
    polyline_result_t e;
    if (results_due.size() == 0) begin
      $error("unexpected result: status %0d lat %0d lng %0d bad_symbol %0d",
             status, lat, lng, bad);
      errors++;
      return;
    end
    e = results_due.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, status);
      errors++;
    end
    if (lat !== e.lat) begin
      $error("lat_value: expected %0d, actual %0d", e.lat, lat);
      errors++;
    end
    if (lng !== e.lng) begin
      $error("lng_value: expected %0d, actual %0d", e.lng, lng);
      errors++;
    end
    if (bad !== e.bad) begin
      $error("bad_symbol: expected %0d, actual %0d", e.bad, bad);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import psd_pkg::*;

  localparam int unsigned CHUNK_LIMIT = MAX_CHUNKS_DEF;
  localparam int          RANDOM_CHARS = 700;
  localparam int          HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();

  polyline_stream_decoder_unit #(.MAX_CHUNKS(CHUNK_LIMIT)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  polyline_tracker tracker;

  bit tx_burst;      // sender skips idle cycles
  bit rx_burst;      // receiver skips stalls
  bit rx_hold_req;   // receiver should hold off for a long stretch
  bit opening;       // next character starts a new string

  initial begin
    clk = 1'b0;
  end
  always #4 clk = ~clk;

  // Watch both channels; every transaction is taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.decode_char(in_ch.symbol, in_ch.first);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.status, out_ch.lat_value, out_ch.lng_value,
                           out_ch.bad_symbol);
  end

  // Offer one character, with a random idle gap in front of it
  task automatic send_char(input logic [7:0] sym, input logic opens);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.first  <= opens;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic emit(input logic [7:0] sym);
    send_char(sym, opening);
    opening = 1'b0;
  endtask

  function automatic logic [7:0] bad_char();
    if ($urandom_range(0, 1))
      return 8'($urandom_range(0, SYM_LOW - 1));
    return 8'($urandom_range(SYM_HIGH + 1, 255));
  endfunction

  // One encoded number of n chunks; closed when 'closed' is set
  task automatic send_number(input int n, input bit closed);
    int          mode;
    logic [4:0]  payload;
    logic [5:0]  chunk;
    mode = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0:       payload = 5'h1F;
        1:       payload = 5'h00;
        default: payload = 5'($urandom_range(0, 31));
      endcase
      chunk = {(i < n - 1) || !closed, payload};
      emit(SYM_LOW + 8'(chunk));
    end
  endtask

  // A string of coordinate pairs, sometimes broken or cut short
  task automatic send_string();
    int roll;
    int len;
    opening  = 1'b1;
    tx_burst = ($urandom_range(0, 3) == 0);
    // pure noise
    if ($urandom_range(0, 14) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) emit(8'($urandom_range(0, 255)));
      return;
    end
    len = 2 * $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // bad character, then a few that are dropped
        emit(bad_char());
        repeat ($urandom_range(0, 3)) emit(8'($urandom_range(0, 255)));
        return;
      end else if (roll < 7) begin
        send_number(CHUNK_LIMIT + 1, 1'b0);
        return;
      end else if (roll < 10) begin
        send_number($urandom_range(1, CHUNK_LIMIT), 1'b0);
        return;
      end else if (roll < 88) begin
        send_number($urandom_range(1, 4), 1'b1);
      end else begin
        send_number($urandom_range(5, CHUNK_LIMIT), 1'b1);
      end
    end
  endtask

  // Park the sender until every expected result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.results_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, bursts, and one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        stall = 0;
      end else begin
        if ($urandom_range(0, 9) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Main stimulus
  initial begin
    int base;
    bit paused;
    tracker      = new(CHUNK_LIMIT);
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    rx_hold_req  = 1'b0;
    opening      = 1'b0;
    paused       = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.symbol <= '0;
    in_ch.first  <= 1'b0;
    rst_n        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero pair, lowest and highest chunk, discarded partial,
    // bad characters at both edges, dropped input, number too long
    send_char(8'd63, 1'b1);
    send_char(8'd63, 1'b0);
    send_char(8'd64, 1'b0);
    send_char(8'd126, 1'b0);
    send_char(8'd94, 1'b0);
    send_char(8'd126, 1'b0);
    send_char(8'd100, 1'b1);
    send_char(8'd65, 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'd70, 1'b0);
    send_char(8'd255, 1'b1);
    send_char(8'd127, 1'b1);
    send_char(8'd62, 1'b1);
    send_char(8'd126, 1'b1);
    repeat (CHUNK_LIMIT) send_char(8'd126, 1'b0);
    drain();

    // receiver holds off while the sender keeps pushing
    rx_hold_req = 1'b1;
    repeat (4) begin
      send_string();
      tx_burst = 1'b1;
    end

    base = tracker.decoded_chars;
    while (tracker.decoded_chars - base < RANDOM_CHARS) begin
      if (!paused && tracker.decoded_chars - base > RANDOM_CHARS / 2) begin
        paused = 1'b1;
        drain();
      end
      send_string();
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.results_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 200000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/psd_pkg.sv
rtl/core/psd_in_if.sv
rtl/core/psd_out_if.sv
rtl/core/psd_front.sv
rtl/core/psd_fifo.sv
rtl/core/psd_back.sv
rtl/core/polyline_stream_decoder_unit.sv
tb/tb_top.sv
